>>> rtl/core/tar_header_checker_core_assert.svh
// Assertion macros for the tar header checker RTL (used by tar_hdr_fifo).
// Each macro expects signals named clk and rst in the module that uses it.
`ifndef TAR_HEADER_CHECKER_CORE_ASSERT_SVH
`define TAR_HEADER_CHECKER_CORE_ASSERT_SVH

// Condition must hold at every clock edge outside reset.
`define TAR_ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TAR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/tar_hdr_pkg.sv
// ---------------------------------------------------------------------------
// tar_hdr_pkg
// Shared types and constants of the tar header checker: block layout,
// status codes and the per-block summary passed from front to back.
// ---------------------------------------------------------------------------
package tar_hdr_pkg;

  localparam int unsigned BLOCK_BYTES = 512;
  localparam int unsigned OFF_W       = $clog2(BLOCK_BYTES);

  localparam logic [OFF_W-1:0] OFF_LAST   = OFF_W'(BLOCK_BYTES - 1);
  localparam logic [OFF_W-1:0] SIZE_FIRST = OFF_W'(124);
  localparam logic [OFF_W-1:0] SIZE_LAST  = OFF_W'(135);
  localparam logic [OFF_W-1:0] CHK_FIRST  = OFF_W'(148);
  localparam logic [OFF_W-1:0] CHK_LAST   = OFF_W'(155);
  localparam logic [OFF_W-1:0] TYPE_OFF   = OFF_W'(156);

  localparam logic [7:0] SPACE_BYTE = 8'h20;
  localparam logic [7:0] MINUS_BYTE = 8'h2d;
  localparam logic [7:0] ZERO_CHAR  = 8'h30;
  localparam logic [7:0] SEVEN_CHAR = 8'h37;
  localparam logic [7:0] TAB_BYTE   = 8'h09;
  localparam logic [7:0] CR_BYTE    = 8'h0d;

  localparam int unsigned TOTAL_W = 18;
  localparam int unsigned CHK_W   = 24;
  localparam int unsigned SIZE_W  = 64;

  typedef enum logic [1:0] {
    ST_VALID        = 2'd0,
    ST_EMPTY        = 2'd1,
    ST_BAD_CHECKSUM = 2'd2,
    ST_SIZE_BAD     = 2'd3
  } tar_status_t;

  // Everything the back end needs to judge one finished block
  typedef struct packed {
    logic               nonzero;
    logic               ck_digits;
    logic               ck_neg;
    logic [CHK_W-1:0]   ck_val;
    logic [TOTAL_W-1:0] u_total;
    logic [TOTAL_W-1:0] s_total;
    logic               sz_ok;
    logic               sz_bin;
    logic [SIZE_W-1:0]  sz_val;
    logic [7:0]         etype;
  } tar_sum_t;

endpackage

>>> rtl/core/tar_hdr_front.sv
// ---------------------------------------------------------------------------
// tar_hdr_front
// Byte front end: tracks the offset in the block, keeps both byte sums,
// parses the checksum and size fields, and emits a summary after byte 511.
// ---------------------------------------------------------------------------
module tar_hdr_front
  import tar_hdr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        take,
  input  logic [7:0]  data_byte,
  output logic        at_last,
  output logic        sum_push,
  output tar_sum_t    sum_data
);

  typedef enum logic [1:0] {
    PH_SKIP   = 2'd0,
    PH_DIGITS = 2'd1,
    PH_DONE   = 2'd2,
    PH_NONE   = 2'd3
  } phase_t;

  logic [OFF_W-1:0]   offset;
  logic [TOTAL_W-1:0] u_total, u_total_next;
  logic [TOTAL_W-1:0] s_total, s_total_next;
  logic [CHK_W-1:0]   ck_val, ck_val_next;
  phase_t             ck_phase, ck_phase_next;
  logic               ck_neg, ck_neg_next;
  logic [SIZE_W-1:0]  sz_val, sz_val_next;
  phase_t             sz_phase, sz_phase_next;
  logic               sz_bin, sz_bin_next;
  logic [7:0]         etype, etype_next;
  logic               nonzero, nonzero_next;

  logic               in_chk, in_size;
  logic               is_blank, is_oct;
  logic [2:0]         digit;
  logic [TOTAL_W-1:0] u_add, s_add;

  assign at_last = (offset == OFF_LAST);

  // Classify the byte and its position
  always_comb begin
    in_chk   = (offset >= CHK_FIRST) && (offset <= CHK_LAST);
    in_size  = (offset >= SIZE_FIRST) && (offset <= SIZE_LAST);
    is_blank = (data_byte == SPACE_BYTE) ||
               ((data_byte >= TAB_BYTE) && (data_byte <= CR_BYTE));
    is_oct   = (data_byte >= ZERO_CHAR) && (data_byte <= SEVEN_CHAR);
    digit    = data_byte[2:0];
  end

  // Sums: checksum bytes count as spaces, signed sum sign-extends the byte
  always_comb begin
    if (in_chk) begin
      u_add = TOTAL_W'(SPACE_BYTE);
      s_add = TOTAL_W'(SPACE_BYTE);
    end else begin
      u_add = {{(TOTAL_W-8){1'b0}}, data_byte};
      s_add = {{(TOTAL_W-8){data_byte[7]}}, data_byte};
    end
    u_total_next = u_total + u_add;
    s_total_next = s_total + s_add;
    nonzero_next = nonzero | (data_byte != 8'd0);
    etype_next   = (offset == TYPE_OFF) ? data_byte : etype;
  end

  // Checksum field octal parser
  always_comb begin
    ck_val_next   = ck_val;
    ck_phase_next = ck_phase;
    ck_neg_next   = ck_neg;
    if (in_chk) begin
      unique case (ck_phase)
        PH_SKIP: begin
          if (is_oct) begin
            ck_val_next   = CHK_W'(digit);
            ck_phase_next = PH_DIGITS;
          end else if (!is_blank) begin
            ck_neg_next   = ck_neg | (data_byte == MINUS_BYTE);
            ck_phase_next = PH_NONE;
          end
        end
        PH_DIGITS: begin
          if (is_oct) ck_val_next = {ck_val[CHK_W-4:0], digit};
          else        ck_phase_next = PH_DONE;
        end
        PH_DONE, PH_NONE: begin
          ck_phase_next = ck_phase;
        end
      endcase
    end
  end

  // Size field: base-256 when byte 124 has its top bit set, else octal
  always_comb begin
    sz_val_next   = sz_val;
    sz_phase_next = sz_phase;
    sz_bin_next   = sz_bin;
    if (in_size) begin
      if ((offset == SIZE_FIRST) && data_byte[7]) begin
        sz_bin_next = 1'b1;
      end else if (sz_bin) begin
        sz_val_next = {sz_val[SIZE_W-9:0], data_byte};
      end else begin
        unique case (sz_phase)
          PH_SKIP: begin
            if (is_oct) begin
              sz_val_next   = SIZE_W'(digit);
              sz_phase_next = PH_DIGITS;
            end else if (!is_blank) begin
              sz_phase_next = PH_NONE;
            end
          end
          PH_DIGITS: begin
            if (is_oct) sz_val_next = {sz_val[SIZE_W-4:0], digit};
            else        sz_phase_next = PH_DONE;
          end
          PH_DONE, PH_NONE: begin
            sz_phase_next = sz_phase;
          end
        endcase
      end
    end
  end

  // Build the block summary from the values after the last byte
  always_comb begin
    sum_push           = take && at_last;
    sum_data.nonzero   = nonzero_next;
    sum_data.ck_digits = (ck_phase_next == PH_DIGITS) || (ck_phase_next == PH_DONE);
    sum_data.ck_neg    = ck_neg_next;
    sum_data.ck_val    = ck_val_next;
    sum_data.u_total   = u_total_next;
    sum_data.s_total   = s_total_next;
    sum_data.sz_ok     = sz_bin_next || (sz_phase_next == PH_DIGITS) ||
                         (sz_phase_next == PH_DONE);
    sum_data.sz_bin    = sz_bin_next;
    sum_data.sz_val    = sz_val_next;
    sum_data.etype     = etype_next;
  end

  // Advance per accepted byte; clear after the last byte of a block
  always_ff @(posedge clk) begin
    if (rst || (take && at_last)) begin
      offset   <= '0;
      u_total  <= '0;
      s_total  <= '0;
      ck_val   <= '0;
      ck_phase <= PH_SKIP;
      ck_neg   <= 1'b0;
      sz_val   <= '0;
      sz_phase <= PH_SKIP;
      sz_bin   <= 1'b0;
      etype    <= '0;
      nonzero  <= 1'b0;
    end else if (take) begin
      offset   <= offset + 1'b1;
      u_total  <= u_total_next;
      s_total  <= s_total_next;
      ck_val   <= ck_val_next;
      ck_phase <= ck_phase_next;
      ck_neg   <= ck_neg_next;
      sz_val   <= sz_val_next;
      sz_phase <= sz_phase_next;
      sz_bin   <= sz_bin_next;
      etype    <= etype_next;
      nonzero  <= nonzero_next;
    end
  end

endmodule

>>> rtl/core/tar_hdr_fifo.sv
// ---------------------------------------------------------------------------
// tar_hdr_fifo
// Short queue of block summaries between the byte front end and the
// result back end.
// ---------------------------------------------------------------------------
`include "tar_header_checker_core_assert.svh"

module tar_hdr_fifo
  import tar_hdr_pkg::*;
#(
  parameter int unsigned DEPTH = 2
)
(
  input  logic     clk,
  input  logic     rst,
  input  logic     wr_en,
  input  tar_sum_t wr_data,
  output logic     q_full,
  input  logic     rd_en,
  output logic     q_empty,
  output tar_sum_t rd_data
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  tar_sum_t        mem [DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CW-1:0]   count;

  assign q_full  = (count == CNT_FULL);
  assign q_empty = (count == '0);
  assign rd_data = mem[rd_ptr];

  // Store the written entry
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      if (rd_en) rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      if (wr_en && !rd_en)      count <= count + 1'b1;
      else if (!wr_en && rd_en) count <= count - 1'b1;
    end
  end

  `TAR_ASSERT_ALWAYS(a_count_bound, count <= CNT_FULL, "summary queue count above depth")
  `TAR_ASSERT_ALWAYS(a_no_overflow, !(wr_en && q_full), "summary queue written while full")
  `TAR_ASSERT_ALWAYS(a_no_underflow, !(rd_en && q_empty), "summary queue read while empty")
  `TAR_ASSERT_NEXT(a_count_up, wr_en && !rd_en, count == $past(count) + 1'b1, "count did not rise")

endmodule

>>> rtl/core/tar_hdr_back.sv
// ---------------------------------------------------------------------------
// tar_hdr_back
// Result back end: judges each block summary and holds the result in an
// output register until the consumer pops it.
// ---------------------------------------------------------------------------
module tar_hdr_back
  import tar_hdr_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                q_empty,
  input  tar_sum_t            q_data,
  output logic                q_pop,
  input  logic                pop,
  output logic                empty,
  output logic [1:0]          status,
  output logic [7:0]          type_flag,
  output logic [SIZE_W-1:0]   entry_size,
  output logic                size_is_binary,
  output logic [TOTAL_W-2:0]  computed_sum,
  output logic [CHK_W-1:0]    header_sum
);

  logic        out_valid;
  logic        match;
  tar_status_t status_next;
  tar_status_t status_q;

  // Decide the status: empty, then bad checksum, then size, then valid
  always_comb begin
    match = (q_data.ck_val == CHK_W'(q_data.u_total)) ||
            (!q_data.s_total[TOTAL_W-1] && (q_data.ck_val == CHK_W'(q_data.s_total)));
    priority if (!q_data.nonzero) begin
      status_next = ST_EMPTY;
    end else if (!q_data.ck_digits || q_data.ck_neg || !match) begin
      status_next = ST_BAD_CHECKSUM;
    end else if (!q_data.sz_ok) begin
      status_next = ST_SIZE_BAD;
    end else begin
      status_next = ST_VALID;
    end
  end

  // Refill the output register when it is free or being taken
  assign q_pop  = !q_empty && (!out_valid || pop);
  assign empty  = !out_valid;
  assign status = status_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (q_pop) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  // Load the result payload
  always_ff @(posedge clk) begin
    if (q_pop) begin
      status_q       <= status_next;
      type_flag      <= q_data.etype;
      entry_size     <= q_data.sz_ok ? q_data.sz_val : '0;
      size_is_binary <= q_data.sz_bin;
      computed_sum   <= q_data.u_total[TOTAL_W-2:0];
      header_sum     <= q_data.ck_val;
    end
  end

endmodule

>>> rtl/core/tar_header_checker_core.sv
// ---------------------------------------------------------------------------
// tar_header_checker_core
// Checks a tar header block streamed one byte per cycle, unless full holds
// the last byte, and reports its checksum status, entry type and entry size.
// ---------------------------------------------------------------------------
// Input channel: push/full with data_byte. Bytes 0 to 511 of each 512-byte
// header block arrive in order, one byte per cycle while full is low, with no gaps needed.
// Output channel: empty/pop. One result per block, carrying status,
// type_flag, entry_size, size_is_binary, computed_sum and header_sum.
// Throughput: one byte per cycle while full is low; the front end keeps
// every sum and field parser updated per byte.
// The summary enters the queue at the edge that accepts byte 511 and moves
// into the output register when that register is empty or being popped.
// When the consumer stalls, finished block summaries collect in the queue of
// QUEUE_DEPTH entries; full rises only at byte 511 of a block whose summary
// has no room, so earlier bytes keep flowing.
// Reset clears the byte offset, sums, parsers, the summary queue and the
// output register; the next byte accepted is offset 0 of a new block.
// ---------------------------------------------------------------------------
module tar_header_checker_core
  import tar_hdr_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 2
)
(
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  logic [7:0]          data_byte,
  input  logic                pop,
  output logic                empty,
  output logic [1:0]          status,
  output logic [7:0]          type_flag,
  output logic [SIZE_W-1:0]   entry_size,
  output logic                size_is_binary,
  output logic [TOTAL_W-2:0]  computed_sum,
  output logic [CHK_W-1:0]    header_sum
);

  logic     take;
  logic     at_last;
  logic     sum_push;
  tar_sum_t sum_data;
  logic     q_full;
  logic     q_empty;
  logic     q_pop;
  tar_sum_t q_data;

  // Hold the input only when the last byte finds no queue room
  assign full = q_full && at_last;
  assign take = push && !full;

  tar_hdr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .data_byte (data_byte),
    .at_last   (at_last),
    .sum_push  (sum_push),
    .sum_data  (sum_data)
  );

  tar_hdr_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (sum_push),
    .wr_data (sum_data),
    .q_full  (q_full),
    .rd_en   (q_pop),
    .q_empty (q_empty),
    .rd_data (q_data)
  );

  tar_hdr_back u_back (
    .clk            (clk),
    .rst            (rst),
    .q_empty        (q_empty),
    .q_data         (q_data),
    .q_pop          (q_pop),
    .pop            (pop),
    .empty          (empty),
    .status         (status),
    .type_flag      (type_flag),
    .entry_size     (entry_size),
    .size_is_binary (size_is_binary),
    .computed_sum   (computed_sum),
    .header_sum     (header_sum)
  );

endmodule

>>> tb/tar_header_checker_core_tb.sv
// ---------------------------------------------------------------------------
// tar_header_checker_core_tb
// Streams whole 512-byte tar header blocks into the checker one item per
// byte. A scoreboard in this module follows the same byte stream, sums and
// field parsers, and keeps one expected verdict per block. Every result popped
// from the core is compared field by field with the oldest pending verdict.
// Directed blocks hit empty blocks, every checksum and size form and the type
// byte; random blocks are mostly well-formed headers with random content.
// ---------------------------------------------------------------------------
module tar_header_checker_core_tb;
  import tar_hdr_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 2000;

  localparam logic [7:0] TYPE_FILE     = "0";
  localparam logic [7:0] TYPE_SYMLINK  = "2";
  localparam logic [7:0] TYPE_DIR      = "5";
  localparam logic [7:0] TYPE_LONGNAME = "L";
  localparam logic [7:0] PLUS_BYTE     = "+";

  // Parser progress through an octal field
  typedef enum logic [1:0] {
    OCT_BLANKS,
    OCT_DIGITS,
    OCT_STOPPED,
    OCT_NONE
  } octal_phase_t;

  // How the size field of a generated header is written
  typedef enum logic [2:0] {
    SZ_OCTAL,
    SZ_FULL,
    SZ_BINARY,
    SZ_NONE,
    SZ_SIGNED
  } size_form_t;

  // How the checksum field of a generated header is written
  typedef enum logic [2:0] {
    CK_UNSIGNED,
    CK_SIGNED,
    CK_BLANKS,
    CK_FULL8,
    CK_MISMATCH,
    CK_MINUS,
    CK_BLANK_ONLY,
    CK_NONOCTAL
  } ck_form_t;

  typedef struct {
    tar_status_t         status;
    logic [7:0]          type_flag;
    logic [SIZE_W-1:0]   entry_size;
    logic                size_is_binary;
    logic [TOTAL_W-2:0]  computed_sum;
    logic [CHK_W-1:0]    header_sum;
  } block_verdict_t;

  logic                clk;
  logic                rst = 1'b1;
  logic                push = 1'b0;
  logic                full;
  logic [7:0]          data_byte = 8'h00;
  logic                pop = 1'b0;
  logic                empty;
  logic [1:0]          status;
  logic [7:0]          type_flag;
  logic [SIZE_W-1:0]   entry_size;
  logic                size_is_binary;
  logic [TOTAL_W-2:0]  computed_sum;
  logic [CHK_W-1:0]    header_sum;

  // Scoreboard state: mirrors the core's per-block parsing
  logic [OFF_W-1:0]    hdr_off = '0;
  logic [TOTAL_W-1:0]  sum_u = '0;
  logic [TOTAL_W-1:0]  sum_s = '0;
  logic [63:0]         chk_acc = '0;
  octal_phase_t        chk_phase = OCT_BLANKS;
  logic                chk_neg = 1'b0;
  logic [63:0]         size_acc = '0;
  octal_phase_t        size_phase = OCT_BLANKS;
  logic                size_bin = 1'b0;
  logic [7:0]          type_byte = 8'h00;
  logic                hdr_nonzero = 1'b0;

  block_verdict_t      pending_verdicts [$];
  logic [7:0]          hdr_buf [BLOCK_BYTES];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int fail_count = 0;
  int results_seen = 0;
  int blocks_sent = 0;
  int bytes_sent = 0;
  int status_tally [4] = '{0, 0, 0, 0};

  tar_header_checker_core i_dut (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .full           (full),
    .data_byte      (data_byte),
    .pop            (pop),
    .empty          (empty),
    .status         (status),
    .type_flag      (type_flag),
    .entry_size     (entry_size),
    .size_is_binary (size_is_binary),
    .computed_sum   (computed_sum),
    .header_sum     (header_sum)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ------------------------------------------------------------------------
  // Scoreboard
  // ------------------------------------------------------------------------
  function automatic logic is_blank_char(logic [7:0] c);
    return c == SPACE_BYTE || (c >= TAB_BYTE && c <= CR_BYTE);
  endfunction

  function automatic logic is_octal_char(logic [7:0] c);
    return c >= ZERO_CHAR && c <= SEVEN_CHAR;
  endfunction

  function automatic octal_phase_t octal_next(octal_phase_t ph, logic [7:0] c);
    if (ph == OCT_BLANKS) begin
      if (is_blank_char(c)) return OCT_BLANKS;
      if (is_octal_char(c)) return OCT_DIGITS;
      return OCT_NONE;
    end
    if (ph == OCT_DIGITS) begin
      if (is_octal_char(c)) return OCT_DIGITS;
      return OCT_STOPPED;
    end
    return ph;
  endfunction

  function automatic logic [63:0] octal_accum(octal_phase_t ph, logic [7:0] c,
                                              logic [63:0] acc);
    if (!is_octal_char(c)) return acc;
    if (ph == OCT_BLANKS) return {61'd0, c[2:0]};
    if (ph == OCT_DIGITS) return {acc[60:0], c[2:0]};
    return acc;
  endfunction

  // Advance the parsers by one accepted item; queue a verdict at block end
  task automatic track_header_byte(input logic [7:0] b);
    logic           chk_ok;
    logic           size_ok;
    logic           match;
    logic [23:0]    rec;
    block_verdict_t v;
    if (b != 8'h00) hdr_nonzero = 1'b1;

    // count the checksum field as spaces and parse it as octal
    if (hdr_off >= CHK_FIRST && hdr_off <= CHK_LAST) begin
      sum_u = sum_u + SPACE_BYTE;
      sum_s = sum_s + SPACE_BYTE;
      if (chk_phase == OCT_BLANKS && b == MINUS_BYTE) chk_neg = 1'b1;
      chk_acc = octal_accum(chk_phase, b, chk_acc);
      chk_phase = octal_next(chk_phase, b);
    end else begin
      sum_u = sum_u + b;
      sum_s = sum_s + {{10{b[7]}}, b};
    end

    // size: base-256 when bit 7 of its first byte is set, else octal
    if (hdr_off >= SIZE_FIRST && hdr_off <= SIZE_LAST) begin
      if (hdr_off == SIZE_FIRST && b[7]) begin
        size_bin = 1'b1;
      end else if (size_bin) begin
        size_acc = {size_acc[55:0], b};
      end else begin
        size_acc = octal_accum(size_phase, b, size_acc);
        size_phase = octal_next(size_phase, b);
      end
    end

    if (hdr_off == TYPE_OFF) type_byte = b;

    if (hdr_off != OFF_LAST) begin
      hdr_off = hdr_off + 1'b1;
      return;
    end

    // judge the finished block
    chk_ok  = chk_phase == OCT_DIGITS || chk_phase == OCT_STOPPED;
    size_ok = size_bin || size_phase == OCT_DIGITS || size_phase == OCT_STOPPED;
    rec     = chk_acc[23:0];
    match   = rec == {6'd0, sum_u} || (!sum_s[17] && rec == {6'd0, sum_s});
    if (!hdr_nonzero)                    v.status = ST_EMPTY;
    else if (!chk_ok || chk_neg || !match) v.status = ST_BAD_CHECKSUM;
    else if (!size_ok)                   v.status = ST_SIZE_BAD;
    else                                 v.status = ST_VALID;
    v.type_flag      = type_byte;
    v.entry_size     = size_ok ? size_acc : '0;
    v.size_is_binary = size_bin;
    v.computed_sum   = sum_u[16:0];
    v.header_sum     = rec;
    pending_verdicts.push_back(v);

    // start over for the next block
    hdr_off     = '0;
    sum_u       = '0;
    sum_s       = '0;
    chk_acc     = '0;
    chk_phase   = OCT_BLANKS;
    chk_neg     = 1'b0;
    size_acc    = '0;
    size_phase  = OCT_BLANKS;
    size_bin    = 1'b0;
    type_byte   = 8'h00;
    hdr_nonzero = 1'b0;
  endtask

  // ------------------------------------------------------------------------
  // Driving and draining
  // ------------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      push <= 1'b0;
    end
    @(negedge clk);
    push      <= 1'b1;
    data_byte <= b;
    do @(posedge clk); while (full);
    track_header_byte(b);
    bytes_sent++;
  endtask

  task automatic send_block();
    for (int i = 0; i < BLOCK_BYTES; i++) send_byte(hdr_buf[i]);
    blocks_sent++;
  endtask

  // Hold the sender until every queued verdict has been matched
  task automatic drain_results();
    @(negedge clk);
    push <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
  endtask

  // Randomly drop pop to stall the result side
  always @(negedge clk) begin
    pop <= !rst && ($urandom_range(99) >= recv_idle_pct);
  end

  // ------------------------------------------------------------------------
  // Header construction
  // ------------------------------------------------------------------------
  task automatic clear_header();
    for (int i = 0; i < BLOCK_BYTES; i++) hdr_buf[i] = 8'h00;
  endtask

  task automatic put_octal(input int off, input int nd, input logic [63:0] val);
    logic [63:0] digit;
    for (int i = 0; i < nd; i++) begin
      digit = val >> (3 * i);
      hdr_buf[off + nd - 1 - i] = ZERO_CHAR + {5'd0, digit[2:0]};
    end
  endtask

  function automatic logic [7:0] pick_blank();
    if ($urandom_range(1) == 0) return SPACE_BYTE;
    return 8'($urandom_range(CR_BYTE, TAB_BYTE));
  endfunction

  // Fill name, mode, uid, gid, size, mtime, type, magic and version; not the checksum
  task automatic build_header(input int name_len, input int name_lo, input int name_hi,
                              input size_form_t sform, input logic [63:0] sval,
                              input logic [7:0] tflag);
    int    nd;
    string magic;
    magic = "ustar";
    clear_header();
    for (int i = 0; i < name_len; i++) hdr_buf[i] = 8'($urandom_range(name_hi, name_lo));
    put_octal(100, 7, 64'($urandom_range(511)));
    put_octal(108, 7, 64'($urandom_range(4095)));
    put_octal(116, 7, 64'($urandom_range(4095)));

    case (sform)
      SZ_OCTAL: begin
        nd = $urandom_range(11, 1);
        for (int i = 0; i < 11 - nd; i++) hdr_buf[SIZE_FIRST + i] = SPACE_BYTE;
        put_octal(SIZE_FIRST + 11 - nd, nd, sval);
        hdr_buf[SIZE_LAST] = ($urandom_range(1) == 0) ? SPACE_BYTE : 8'h00;
      end
      SZ_FULL: put_octal(SIZE_FIRST, 12, sval);
      SZ_BINARY: begin
        hdr_buf[SIZE_FIRST] = ($urandom_range(1) == 0) ? 8'h80 : 8'($urandom_range(255, 128));
        for (int i = 1; i < 4; i++) hdr_buf[SIZE_FIRST + i] = 8'($urandom_range(255));
        for (int i = 0; i < 8; i++) hdr_buf[SIZE_LAST - i] = sval[8*i +: 8];
      end
      SZ_SIGNED: begin
        hdr_buf[SIZE_FIRST] = ($urandom_range(1) == 0) ? MINUS_BYTE : PLUS_BYTE;
        put_octal(SIZE_FIRST + 1, 10, sval);
      end
      default: ;  // no digits at all: leave the field NUL
    endcase

    put_octal(136, 11, {$urandom, $urandom});
    hdr_buf[TYPE_OFF] = tflag;
    for (int i = 0; i < 5; i++) hdr_buf[257 + i] = magic[i];
    hdr_buf[263] = ZERO_CHAR;
    hdr_buf[264] = ZERO_CHAR;
  endtask

  // Write the checksum field from the sums of the rest of the block
  task automatic seal_checksum(input ck_form_t form);
    logic [17:0] u;
    logic [17:0] s;
    u = '0;
    s = '0;
    for (int i = 0; i < BLOCK_BYTES; i++) begin
      if (i >= CHK_FIRST && i <= CHK_LAST) begin
        u = u + SPACE_BYTE;
        s = s + SPACE_BYTE;
      end else begin
        u = u + hdr_buf[i];
        s = s + {{10{hdr_buf[i][7]}}, hdr_buf[i]};
      end
    end
    for (int i = CHK_FIRST; i <= CHK_LAST; i++) hdr_buf[i] = SPACE_BYTE;

    case (form)
      CK_UNSIGNED: begin
        put_octal(CHK_FIRST, 6, 64'(u));
        hdr_buf[CHK_FIRST + 6] = 8'h00;
      end
      CK_SIGNED: begin
        put_octal(CHK_FIRST, 6, 64'(s));
        hdr_buf[CHK_FIRST + 6] = 8'h00;
      end
      CK_BLANKS: begin
        hdr_buf[CHK_FIRST]     = pick_blank();
        hdr_buf[CHK_FIRST + 1] = pick_blank();
        put_octal(CHK_FIRST + 2, 6, 64'(u));
      end
      CK_FULL8: put_octal(CHK_FIRST, 8, 64'(u));
      CK_MISMATCH: begin
        put_octal(CHK_FIRST, 6, 64'(u ^ (18'd1 << $urandom_range(16))));
        hdr_buf[CHK_FIRST + 6] = 8'h00;
      end
      CK_MINUS: begin
        hdr_buf[CHK_FIRST] = MINUS_BYTE;
        put_octal(CHK_FIRST + 1, 6, 64'(u));
      end
      CK_NONOCTAL: begin
        hdr_buf[CHK_FIRST] = ZERO_CHAR + 8'd8;
        put_octal(CHK_FIRST + 1, 6, 64'(u));
      end
      default: ;  // blanks only
    endcase
  endtask

  task automatic send_header(input size_form_t sform, input logic [63:0] sval,
                             input logic [7:0] tflag, input ck_form_t ck);
    build_header($urandom_range(100, 1), 33, 126, sform, sval, tflag);
    seal_checksum(ck);
    send_block();
  endtask

  // ------------------------------------------------------------------------
  // Tests
  // ------------------------------------------------------------------------
  task automatic test_empty_block();
    clear_header();
    send_block();
    // one nonzero byte at the very end is enough to leave the empty case
    clear_header();
    hdr_buf[OFF_LAST] = 8'h01;
    send_block();
  endtask

  task automatic test_checksum_forms();
    send_header(SZ_OCTAL, 64'd1234, TYPE_FILE, CK_UNSIGNED);
    build_header(60, 128, 255, SZ_OCTAL, 64'd777, TYPE_FILE);
    seal_checksum(CK_SIGNED);
    send_block();
    send_header(SZ_OCTAL, 64'd42, TYPE_FILE, CK_BLANKS);
    send_header(SZ_OCTAL, 64'd9, TYPE_FILE, CK_FULL8);
    // a name of 0x80 bytes drives the signed sum negative: it never matches
    build_header(100, 128, 128, SZ_OCTAL, 64'd5, TYPE_FILE);
    seal_checksum(CK_SIGNED);
    send_block();
    seal_checksum(CK_UNSIGNED);
    send_block();
  endtask

  task automatic test_checksum_errors();
    send_header(SZ_OCTAL, 64'd100, TYPE_FILE, CK_MISMATCH);
    send_header(SZ_OCTAL, 64'd100, TYPE_FILE, CK_MINUS);
    send_header(SZ_OCTAL, 64'd100, TYPE_FILE, CK_BLANK_ONLY);
    send_header(SZ_OCTAL, 64'd100, TYPE_FILE, CK_NONOCTAL);
  endtask

  task automatic test_size_forms();
    send_header(SZ_OCTAL, {$urandom, $urandom}, TYPE_FILE, CK_UNSIGNED);
    send_header(SZ_FULL, '1, TYPE_DIR, CK_UNSIGNED);
    send_header(SZ_BINARY, '1, TYPE_FILE, CK_UNSIGNED);
    send_header(SZ_BINARY, {$urandom, $urandom}, TYPE_FILE, CK_UNSIGNED);
    send_header(SZ_NONE, '0, TYPE_FILE, CK_UNSIGNED);
    send_header(SZ_SIGNED, 64'd123, TYPE_FILE, CK_UNSIGNED);
  endtask

  task automatic test_type_flags();
    send_header(SZ_OCTAL, 64'd0, TYPE_SYMLINK, CK_UNSIGNED);
    send_header(SZ_OCTAL, 64'd64, TYPE_LONGNAME, CK_UNSIGNED);
    send_header(SZ_OCTAL, 64'd1, 8'hff, CK_SIGNED);
  endtask

  task automatic test_byte_extremes();
    for (int i = 0; i < BLOCK_BYTES; i++) hdr_buf[i] = 8'hff;
    send_block();
  endtask

  task automatic test_random_headers(input int n_blocks, input int tx_idle,
                                     input int rx_idle);
    int          pick;
    size_form_t  sform;
    ck_form_t    ck;
    logic [7:0]  tflag;
    logic [63:0] sval;
    send_idle_pct = tx_idle;
    recv_idle_pct = rx_idle;
    for (int n = 0; n < n_blocks; n++) begin
      sval = {$urandom, $urandom} >> $urandom_range(63);

      pick = $urandom_range(99);
      if (pick < 60)      sform = SZ_OCTAL;
      else if (pick < 70) sform = SZ_FULL;
      else if (pick < 85) sform = SZ_BINARY;
      else if (pick < 93) sform = SZ_NONE;
      else                sform = SZ_SIGNED;

      pick = $urandom_range(99);
      if (pick < 50)      ck = CK_UNSIGNED;
      else if (pick < 65) ck = CK_SIGNED;
      else if (pick < 75) ck = CK_BLANKS;
      else if (pick < 80) ck = CK_FULL8;
      else if (pick < 85) ck = CK_MISMATCH;
      else if (pick < 90) ck = CK_MINUS;
      else if (pick < 95) ck = CK_BLANK_ONLY;
      else                ck = CK_NONOCTAL;

      case ($urandom_range(4))
        0:       tflag = TYPE_FILE;
        1:       tflag = TYPE_SYMLINK;
        2:       tflag = TYPE_LONGNAME;
        3:       tflag = TYPE_DIR;
        default: tflag = 8'($urandom_range(255));
      endcase

      if ($urandom_range(99) < 8) begin
        // raw noise block
        for (int i = 0; i < BLOCK_BYTES; i++) hdr_buf[i] = 8'($urandom_range(255));
      end else begin
        build_header($urandom_range(100, 1), 33,
                     ($urandom_range(3) == 0) ? 255 : 126, sform, sval, tflag);
        if ($urandom_range(3) == 0)
          for (int i = 345; i < 500; i++) hdr_buf[i] = 8'($urandom_range(255));
        seal_checksum(ck);
      end
      send_block();
      if ($urandom_range(9) == 0) drain_results();
    end
  endtask

  // ------------------------------------------------------------------------
  // Result checking
  // ------------------------------------------------------------------------
  always @(posedge clk) begin : check_results
    block_verdict_t want;
    if (!rst && pop && !empty) begin
      if (pending_verdicts.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("Unexpected result: status %0d type %h size %h", status, type_flag,
                   entry_size);
      end else begin
        want = pending_verdicts.pop_front();
        results_seen++;
        status_tally[want.status]++;
        if (status !== want.status || type_flag !== want.type_flag ||
            entry_size !== want.entry_size || size_is_binary !== want.size_is_binary ||
            computed_sum !== want.computed_sum || header_sum !== want.header_sum) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("Mismatch on block %0d", results_seen);
            $display("  expected status %0d type %h size %h bin %b sum %h rec %h",
                     want.status, want.type_flag, want.entry_size, want.size_is_binary,
                     want.computed_sum, want.header_sum);
            $display("  actual   status %0d type %h size %h bin %b sum %h rec %h",
                     status, type_flag, entry_size, size_is_binary, computed_sum,
                     header_sum);
          end
        end
      end
    end
  end

  // End the run when no item moves on either side for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (push && !full) || (pop && !empty)) quiet = 0;
      else quiet++;
    end
    $display("Watchdog: no handshake for %0d cycles, %0d verdicts pending", STALL_LIMIT,
             pending_verdicts.size());
    $display("Some tests failed");
    $finish;
  end

  // ------------------------------------------------------------------------
  // Sequence
  // ------------------------------------------------------------------------
  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_idle_pct = 30;
    recv_idle_pct = 77;
    test_empty_block();
    test_checksum_forms();
    test_checksum_errors();
    test_size_forms();
    test_type_flags();
    test_byte_extremes();
    drain_results();

    test_random_headers(14, 30, 77);
    drain_results();
    test_random_headers(14, 77, 30);
    drain_results();
    test_random_headers(14, 0, 0);
    drain_results();
    repeat (8) @(posedge clk);

    $display("Streamed %0d header blocks (%0d bytes) under three idle patterns, %0d checked.",
             blocks_sent, bytes_sent, results_seen);
    $display("Verdicts: %0d valid, %0d empty, %0d bad checksum, %0d size unreadable.",
             status_tally[ST_VALID], status_tally[ST_EMPTY],
             status_tally[ST_BAD_CHECKSUM], status_tally[ST_SIZE_BAD]);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl/core
rtl/core/tar_hdr_pkg.sv
rtl/core/tar_hdr_front.sv
rtl/core/tar_hdr_fifo.sv
rtl/core/tar_hdr_back.sv
rtl/core/tar_header_checker_core.sv
tb/tar_header_checker_core_tb.sv
